// ===== hdl/ppmd_pkg.sv =====
// Package for the PPM raw stream decoder: result kinds, header field and
// colour component codes, character constants and byte classifiers.
// No dependencies; compiled first.
package ppmd_pkg;

  // Kind of a result request.
  typedef enum logic [1:0] {
    KIND_HEADER    = 2'd0,
    KIND_PIXEL     = 2'd1,
    KIND_BAD_MAGIC = 2'd2
  } kind_t;

  // Header token being read.
  typedef enum logic [1:0] {
    FIELD_WIDTH  = 2'd0,
    FIELD_HEIGHT = 2'd1,
    FIELD_MAXVAL = 2'd2,
    FIELD_DONE   = 2'd3
  } field_t;

  // Colour component expected next in the pixel data.
  typedef enum logic [1:0] {
    COMP_RED   = 2'd0,
    COMP_GREEN = 2'd1,
    COMP_BLUE  = 2'd2
  } comp_t;

  localparam logic [7:0] CHAR_P     = 8'h50;
  localparam logic [7:0] CHAR_SIX   = 8'h36;
  localparam logic [7:0] CHAR_HASH  = 8'h23;
  localparam logic [7:0] CHAR_LF    = 8'h0A;
  localparam logic [7:0] CHAR_SPACE = 8'h20;
  localparam logic [7:0] CHAR_ZERO  = 8'h30;
  localparam logic [7:0] CHAR_NINE  = 8'h39;
  localparam logic [7:0] CHAR_TAB   = 8'h09;
  localparam logic [7:0] CHAR_CR    = 8'h0D;

  // Whitespace as the format defines it: space, tab, LF, VT, FF and CR.
  function automatic logic is_blank(input logic [7:0] c);
    logic res;
    res = (c == CHAR_SPACE) || (c inside {[CHAR_TAB:CHAR_CR]});
    return res;
  endfunction

  // Decimal digit.
  function automatic logic is_digit(input logic [7:0] c);
    logic res;
    res = c inside {[CHAR_ZERO:CHAR_NINE]};
    return res;
  endfunction

endpackage

// ===== hdl/ppmd_in_if.sv =====
// Byte channel into the decoder: valid/ready handshake with the stream byte
// and a start of file flag. Depends on nothing.
interface ppmd_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_byte;
  logic       start_of_file;

  modport source (output valid, output in_byte, output start_of_file, input ready);
  modport sink   (input valid, input in_byte, input start_of_file, output ready);
endinterface

// ===== hdl/ppmd_out_if.sv =====
// Result channel out of the decoder: valid/ready handshake with header,
// pixel or error fields. Depends on ppmd_pkg.
interface ppmd_out_if #(
  parameter int DIM_BITS = 16
);
  logic                  valid;
  logic                  ready;
  ppmd_pkg::kind_t       kind;
  logic [DIM_BITS-1:0]   width;
  logic [DIM_BITS-1:0]   height;
  logic [DIM_BITS-1:0]   max_value;
  logic [DIM_BITS-1:0]   pixel_x;
  logic [DIM_BITS-1:0]   pixel_y;
  logic [7:0]            red;
  logic [7:0]            green;
  logic [7:0]            blue;
  logic                  last;

  modport source (output valid, output kind, output width, output height,
                  output max_value, output pixel_x, output pixel_y, output red,
                  output green, output blue, output last, input ready);
  modport sink   (input valid, input kind, input width, input height,
                  input max_value, input pixel_x, input pixel_y, input red,
                  input green, input blue, input last, output ready);
endinterface

// ===== hdl/ppm_raw_stream_decoder_unit.sv =====
// Top level of the binary PPM (P6) stream decoder: parser core plus output
// skid register. Depends on ppmd_pkg, ppmd_in_if, ppmd_out_if, ppmd_core, ppmd_skid.
//
// Usage:
//   in_chan carries one file byte per request, with start_of_file set on the
//   'P' that opens each file. out_chan carries at most one result per byte:
//   a header (width, height, max_value), a pixel (pixel_x, pixel_y, red,
//   green, blue, last) or a bad magic error.
//   Throughput is one byte per cycle while in_chan.ready is high; the per-byte
//   parser logic sits between the state registers and the output register, or
//   the skid register on a stall; out_chan is driven from the output register.
//   When the receiver stalls, the output register holds its result and a
//   skid register takes one more; in_chan.ready then falls until the receiver
//   drains the skid register.
//   Reset (rst_n low at a clock edge) empties both output registers and puts
//   the parser into its idle state, where bytes without start_of_file are
//   dropped. A byte with start_of_file restarts parsing from any state and no
//   partial result of the old file is sent.
//   DIM_BITS sets the width of the header values and pixel coordinates; token
//   values saturate at 2**DIM_BITS - 1.
module ppm_raw_stream_decoder_unit #(
  parameter int DIM_BITS = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  ppmd_in_if.sink     in_chan,
  ppmd_out_if.source  out_chan
);
  import ppmd_pkg::*;

  localparam int RES_W = 2 + 5 * DIM_BITS + 24 + 1;

  logic                acc;
  logic                space;
  logic                res_valid;
  kind_t               res_kind;
  logic [DIM_BITS-1:0] res_width;
  logic [DIM_BITS-1:0] res_height;
  logic [DIM_BITS-1:0] res_max_value;
  logic [DIM_BITS-1:0] res_pixel_x;
  logic [DIM_BITS-1:0] res_pixel_y;
  logic [7:0]          res_red;
  logic [7:0]          res_green;
  logic [7:0]          res_blue;
  logic                res_last;
  logic [RES_W-1:0]    res_data;
  logic [RES_W-1:0]    out_data;

  assign in_chan.ready = space;
  assign acc           = in_chan.valid && space;

  // Parser state and per-byte logic.
  ppmd_core #(
    .DIM_BITS (DIM_BITS)
  ) u_core (
    .clk           (clk),
    .rst_n         (rst_n),
    .acc           (acc),
    .in_byte       (in_chan.in_byte),
    .start_of_file (in_chan.start_of_file),
    .res_valid     (res_valid),
    .res_kind      (res_kind),
    .res_width     (res_width),
    .res_height    (res_height),
    .res_max_value (res_max_value),
    .res_pixel_x   (res_pixel_x),
    .res_pixel_y   (res_pixel_y),
    .res_red       (res_red),
    .res_green     (res_green),
    .res_blue      (res_blue),
    .res_last      (res_last)
  );

  assign res_data = {res_kind, res_width, res_height, res_max_value, res_pixel_x,
                     res_pixel_y, res_red, res_green, res_blue, res_last};

  // Result register with skid stage.
  ppmd_skid #(
    .DATA_W (RES_W)
  ) u_skid (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (acc && res_valid),
    .push_data (res_data),
    .space     (space),
    .out_valid (out_chan.valid),
    .out_data  (out_data),
    .out_ready (out_chan.ready)
  );

  // Unpack the result fields.
  assign out_chan.kind      = kind_t'(out_data[RES_W-1 -: 2]);
  assign out_chan.width     = out_data[RES_W-3 -: DIM_BITS];
  assign out_chan.height    = out_data[RES_W-3-DIM_BITS -: DIM_BITS];
  assign out_chan.max_value = out_data[RES_W-3-2*DIM_BITS -: DIM_BITS];
  assign out_chan.pixel_x   = out_data[RES_W-3-3*DIM_BITS -: DIM_BITS];
  assign out_chan.pixel_y   = out_data[RES_W-3-4*DIM_BITS -: DIM_BITS];
  assign out_chan.red       = out_data[24 -: 8];
  assign out_chan.green     = out_data[16 -: 8];
  assign out_chan.blue      = out_data[8 -: 8];
  assign out_chan.last      = out_data[0];

  // The skid register only fills behind a full output register.
  a_skid_behind_out: assert property (@(posedge clk) disable iff (!rst_n)
    !space |-> out_chan.valid)
    else $error("skid register full while output register empty");

  // A file whose first byte is not 'P' always produces an error request.
  a_bad_magic_push: assert property (@(posedge clk) disable iff (!rst_n)
    (acc && in_chan.start_of_file && in_chan.in_byte != CHAR_P)
      |-> (res_valid && res_kind == KIND_BAD_MAGIC))
    else $error("bad magic byte taken without an error request");

  // Nothing is offered in the cycle after reset.
  a_reset_empty: assert property (@(posedge clk)
    $past(!rst_n) |-> (!out_chan.valid && space))
    else $error("output not empty after reset");

endmodule

// ===== hdl/ppmd_core.sv =====
// Parser core: holds the decoder state and, for each accepted byte, works out
// the next state and at most one result request. Depends on ppmd_pkg.
module ppmd_core #(
  parameter int DIM_BITS = 16
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  acc,
  input  logic [7:0]            in_byte,
  input  logic                  start_of_file,
  output logic                  res_valid,
  output ppmd_pkg::kind_t       res_kind,
  output logic [DIM_BITS-1:0]   res_width,
  output logic [DIM_BITS-1:0]   res_height,
  output logic [DIM_BITS-1:0]   res_max_value,
  output logic [DIM_BITS-1:0]   res_pixel_x,
  output logic [DIM_BITS-1:0]   res_pixel_y,
  output logic [7:0]            res_red,
  output logic [7:0]            res_green,
  output logic [7:0]            res_blue,
  output logic                  res_last
);
  import ppmd_pkg::*;

  localparam int EXT_BITS = DIM_BITS + 4;

  typedef enum logic [1:0] {
    PH_IDLE = 2'd0,
    PH_SIX  = 2'd1,
    PH_HEAD = 2'd2,
    PH_PIX  = 2'd3
  } phase_t;

  phase_t              phase_r, phase_nxt;
  logic                in_comment_r, in_comment_nxt;
  logic [DIM_BITS-1:0] token_r, token_nxt;
  logic                started_r, started_nxt;
  logic                stopped_r, stopped_nxt;
  field_t              field_r, field_nxt;
  logic [DIM_BITS-1:0] width_r, width_nxt;
  logic [DIM_BITS-1:0] height_r, height_nxt;
  logic [DIM_BITS-1:0] maxval_r, maxval_nxt;
  logic [DIM_BITS-1:0] col_r, col_nxt;
  logic [DIM_BITS-1:0] row_r, row_nxt;
  comp_t               comp_r, comp_nxt;
  logic [7:0]          red_r, red_nxt;
  logic [7:0]          green_r, green_nxt;

  logic                hdr_go;
  logic                empty;
  logic [EXT_BITS-1:0] acc_val;
  logic [DIM_BITS:0]   x_inc;
  logic [DIM_BITS:0]   y_inc;
  logic                lastx;
  logic                lastp;

  // Decimal accumulation as shifts and adds, saturating at the field maximum.
  always_comb begin
    acc_val = (EXT_BITS'(token_r) << 3) + (EXT_BITS'(token_r) << 1)
            + EXT_BITS'(in_byte - CHAR_ZERO);
  end

  // Pixel position bookkeeping.
  always_comb begin
    x_inc = {1'b0, col_r} + (DIM_BITS+1)'(1);
    y_inc = {1'b0, row_r} + (DIM_BITS+1)'(1);
    lastx = x_inc >= {1'b0, width_r};
    lastp = lastx && (y_inc >= {1'b0, height_r});
  end

  // Next state and result for the byte on the input.
  always_comb begin
    phase_nxt      = phase_r;
    in_comment_nxt = in_comment_r;
    token_nxt      = token_r;
    started_nxt    = started_r;
    stopped_nxt    = stopped_r;
    field_nxt      = field_r;
    width_nxt      = width_r;
    height_nxt     = height_r;
    maxval_nxt     = maxval_r;
    col_nxt        = col_r;
    row_nxt        = row_r;
    comp_nxt       = comp_r;
    red_nxt        = red_r;
    green_nxt      = green_r;
    hdr_go         = 1'b0;
    empty          = 1'b0;

    res_valid     = 1'b0;
    res_kind      = KIND_BAD_MAGIC;
    res_width     = '0;
    res_height    = '0;
    res_max_value = '0;
    res_pixel_x   = '0;
    res_pixel_y   = '0;
    res_red       = '0;
    res_green     = '0;
    res_blue      = '0;
    res_last      = 1'b0;

    if (start_of_file) begin
      // A new file drops all progress; its first byte must be the 'P'.
      in_comment_nxt = 1'b0;
      token_nxt      = '0;
      started_nxt    = 1'b0;
      stopped_nxt    = 1'b0;
      field_nxt      = FIELD_WIDTH;
      width_nxt      = '0;
      height_nxt     = '0;
      maxval_nxt     = '0;
      col_nxt        = '0;
      row_nxt        = '0;
      comp_nxt       = COMP_RED;
      red_nxt        = '0;
      green_nxt      = '0;
      if (in_byte == CHAR_P) begin
        phase_nxt = PH_SIX;
      end else begin
        phase_nxt = PH_IDLE;
        res_valid = 1'b1;
      end
    end else begin
      case (phase_r)
        PH_SIX: begin
          if (in_byte == CHAR_SIX) begin
            phase_nxt = PH_HEAD;
          end else begin
            phase_nxt = PH_IDLE;
            res_valid = 1'b1;
          end
        end
        PH_HEAD: begin
          if (in_comment_r) begin
            // A comment runs to the line end; that LF may close the header.
            if (in_byte == CHAR_LF) begin
              in_comment_nxt = 1'b0;
              hdr_go         = (field_r == FIELD_DONE);
            end
          end else if (in_byte == CHAR_HASH || is_blank(in_byte)) begin
            if (in_byte == CHAR_HASH) begin
              in_comment_nxt = 1'b1;
            end
            if (started_r) begin
              token_nxt   = '0;
              started_nxt = 1'b0;
              stopped_nxt = 1'b0;
              case (field_r)
                FIELD_WIDTH:  width_nxt  = token_r;
                FIELD_HEIGHT: height_nxt = token_r;
                default:      maxval_nxt = token_r;
              endcase
              field_nxt = field_t'(field_r + 2'd1);
              hdr_go    = (field_r == FIELD_MAXVAL) && (in_byte != CHAR_HASH);
            end
          end else begin
            // Token byte: leading digits build the value, anything else stops it.
            started_nxt = 1'b1;
            if (!stopped_r) begin
              if (is_digit(in_byte)) begin
                if (acc_val[EXT_BITS-1:DIM_BITS] != '0) begin
                  token_nxt = '1;
                end else begin
                  token_nxt = acc_val[DIM_BITS-1:0];
                end
              end else begin
                stopped_nxt = 1'b1;
              end
            end
          end
        end
        PH_PIX: begin
          case (comp_r)
            COMP_RED: begin
              red_nxt  = in_byte;
              comp_nxt = COMP_GREEN;
            end
            COMP_GREEN: begin
              green_nxt = in_byte;
              comp_nxt  = COMP_BLUE;
            end
            default: begin
              comp_nxt    = COMP_RED;
              res_valid   = 1'b1;
              res_kind    = KIND_PIXEL;
              res_pixel_x = col_r;
              res_pixel_y = row_r;
              res_red     = red_r;
              res_green   = green_r;
              res_blue    = in_byte;
              res_last    = lastp;
              if (lastp) begin
                phase_nxt = PH_IDLE;
              end else if (lastx) begin
                col_nxt = '0;
                row_nxt = y_inc[DIM_BITS-1:0];
              end else begin
                col_nxt = x_inc[DIM_BITS-1:0];
              end
            end
          endcase
        end
        default: begin
        end
      endcase

      // Header complete: report it and start the pixel scan, unless empty.
      if (hdr_go) begin
        empty         = (width_nxt == '0) || (height_nxt == '0);
        phase_nxt     = empty ? PH_IDLE : PH_PIX;
        col_nxt       = '0;
        row_nxt       = '0;
        comp_nxt      = COMP_RED;
        res_valid     = 1'b1;
        res_kind      = KIND_HEADER;
        res_width     = width_nxt;
        res_height    = height_nxt;
        res_max_value = maxval_nxt;
        res_last      = empty;
      end
    end
  end

  // State registers, updated only when a byte is taken.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r      <= PH_IDLE;
      in_comment_r <= 1'b0;
      token_r      <= '0;
      started_r    <= 1'b0;
      stopped_r    <= 1'b0;
      field_r      <= FIELD_WIDTH;
      width_r      <= '0;
      height_r     <= '0;
      maxval_r     <= '0;
      col_r        <= '0;
      row_r        <= '0;
      comp_r       <= COMP_RED;
      red_r        <= '0;
      green_r      <= '0;
    end else if (acc) begin
      phase_r      <= phase_nxt;
      in_comment_r <= in_comment_nxt;
      token_r      <= token_nxt;
      started_r    <= started_nxt;
      stopped_r    <= stopped_nxt;
      field_r      <= field_nxt;
      width_r      <= width_nxt;
      height_r     <= height_nxt;
      maxval_r     <= maxval_nxt;
      col_r        <= col_nxt;
      row_r        <= row_nxt;
      comp_r       <= comp_nxt;
      red_r        <= red_nxt;
      green_r      <= green_nxt;
    end
  end

endmodule

// ===== hdl/ppmd_skid.sv =====
// Output register with a skid stage, so that a new request can be taken in
// the cycle a stall first shows. Depends on ppmd_pkg (house import only).
module ppmd_skid #(
  parameter int DATA_W = 8
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              push,
  input  logic [DATA_W-1:0] push_data,
  output logic              space,
  output logic              out_valid,
  output logic [DATA_W-1:0] out_data,
  input  logic              out_ready
);
  import ppmd_pkg::*;

  logic              out_valid_r;
  logic [DATA_W-1:0] out_data_r;
  logic              skid_valid_r;
  logic [DATA_W-1:0] skid_data_r;

  assign space     = !skid_valid_r;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // Control flags.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else if (!out_valid_r || out_ready) begin
      if (skid_valid_r) begin
        out_valid_r  <= 1'b1;
        skid_valid_r <= 1'b0;
      end else begin
        out_valid_r <= push;
      end
    end else if (push) begin
      skid_valid_r <= 1'b1;
    end
  end

  // Payload moves without reset.
  always_ff @(posedge clk) begin
    if (!out_valid_r || out_ready) begin
      if (skid_valid_r) begin
        out_data_r <= skid_data_r;
      end else if (push) begin
        out_data_r <= push_data;
      end
    end else if (push) begin
      skid_data_r <= push_data;
    end
  end

endmodule
